// ----- rtl/multi_channel_message_fifo_macros.svh -----
// Assertion macros for the multi-channel message FIFO.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef MULTI_CHANNEL_MESSAGE_FIFO_MACROS_SVH
`define MULTI_CHANNEL_MESSAGE_FIFO_MACROS_SVH

// same-cycle implication
`define MCMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mcmf_pkg.sv -----
// Shared types and codes for the multi-channel message FIFO.
// No dependencies; used by mcmf_ctrl, mcmf_datapath and the top level.
`default_nettype none

package mcmf_pkg;

  localparam int KindW    = 2;
  localparam int ChanW    = 8;
  localparam int MsgPortW = 64;
  localparam int StatusW  = 3;
  localparam int PendW    = 5;
  localparam int MaskW    = 16;

  localparam logic [KindW-1:0] KIND_ENQ   = 2'd0;
  localparam logic [KindW-1:0] KIND_DEQ   = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KindW-1:0] KIND_QUERY = 2'd3;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd2;
  localparam logic [StatusW-1:0] ST_EMPTY   = 3'd3;
  localparam logic [StatusW-1:0] ST_TIMEOUT = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mcmf_ctrl.sv -----
// Controller state machine for the multi-channel message FIFO.
// Depends on mcmf_pkg; drives load/exec/respond commands to mcmf_datapath.
`default_nettype none

module mcmf_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  output mcmf_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q != S_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q == S_EXEC);
  assign cmd_o.load    = accept;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.respond = (state_q == S_RESP);

endmodule

`default_nettype wire

// ----- rtl/mcmf_datapath.sv -----
// Datapath of the multi-channel message FIFO: request registers, pointer
// memory with valid bits, message memory and result registers. Uses mcmf_pkg.
`default_nettype none

module mcmf_datapath #(
  parameter int CHANNELS  = 16,
  parameter int DEPTH     = 16,
  parameter int MSG_WIDTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mcmf_pkg::cmd_t                   cmd_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [mcmf_pkg::MaskW-1:0]       cfg_data_i,
  input  wire logic [mcmf_pkg::KindW-1:0]       kind_i,
  input  wire logic [mcmf_pkg::ChanW-1:0]       channel_i,
  input  wire logic [mcmf_pkg::MsgPortW-1:0]    message_in_i,
  input  wire logic                             blocking_i,
  output logic [mcmf_pkg::StatusW-1:0]          status_o,
  output logic [mcmf_pkg::MsgPortW-1:0]         message_out_o,
  output logic [mcmf_pkg::PendW-1:0]            pending_o,
  output logic                                  is_full_o,
  output logic                                  is_empty_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SlotW  = $clog2(DEPTH);
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int PtrW   = 2 * SlotW + CntW;
  localparam int MsgEntries = 2 ** (ChIdxW + SlotW);

  // open mask
  logic [mcmf_pkg::MaskW-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_data_i;
    end
  end

  // request capture
  logic                          in_range, open_ch;
  logic [ChIdxW-1:0]             ch_idx;
  logic [mcmf_pkg::KindW-1:0]    kind_q;
  logic                          in_range_q, open_q, blk_q;
  logic [ChIdxW-1:0]             ch_q;
  logic [MSG_WIDTH-1:0]          msg_q;

  assign in_range = (channel_i < mcmf_pkg::ChanW'(CHANNELS));
  assign ch_idx   = in_range ? channel_i[ChIdxW-1:0] : '0;
  assign open_ch  = in_range && (channel_i < mcmf_pkg::ChanW'(mcmf_pkg::MaskW)) &&
                    mask_q[channel_i[3:0]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= kind_i;
      in_range_q <= in_range;
      open_q     <= open_ch;
      blk_q      <= blocking_i;
      ch_q       <= ch_idx;
      msg_q      <= message_in_i[MSG_WIDTH-1:0];
    end
  end

  // pointer memory: {head, tail, count} per channel
  logic [PtrW-1:0]     ptr_mem [CHANNELS];
  logic [CHANNELS-1:0] ptr_valid_q;
  logic [PtrW-1:0]     ptr_rd_q;
  logic                ptr_rd_valid_q;
  logic                ptr_we;
  logic [PtrW-1:0]     ptr_wd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ptr_rd_q <= ptr_mem[ch_idx];
    end
    if (ptr_we) begin
      ptr_mem[ch_q] <= ptr_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_valid_q    <= '0;
      ptr_rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) ptr_rd_valid_q <= ptr_valid_q[ch_idx];
      if (ptr_we)     ptr_valid_q[ch_q] <= 1'b1;
    end
  end

  logic [SlotW-1:0] head, tail, head_d, tail_d;
  logic [CntW-1:0]  cnt, cnt_d;

  assign {head, tail, cnt} = ptr_rd_valid_q ? ptr_rd_q : '0;
  assign ptr_wd = {head_d, tail_d, cnt_d};

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] p);
    next_slot = (p == SlotW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // request decision
  logic [mcmf_pkg::StatusW-1:0] status_d;
  logic                         msg_we, msg_re;

  always_comb begin
    status_d = mcmf_pkg::ST_OK;
    head_d   = head;
    tail_d   = tail;
    cnt_d    = cnt;
    ptr_we   = 1'b0;
    msg_we   = 1'b0;
    msg_re   = 1'b0;
    case (kind_q)
      mcmf_pkg::KIND_ENQ: begin
        if (!open_q) begin
          status_d = mcmf_pkg::ST_INVALID;
        end else if (cnt >= CntW'(DEPTH)) begin
          status_d = mcmf_pkg::ST_FULL;
        end else begin
          tail_d = next_slot(tail);
          cnt_d  = cnt + 1'b1;
          ptr_we = cmd_i.exec;
          msg_we = cmd_i.exec;
        end
      end
      mcmf_pkg::KIND_DEQ: begin
        if (!open_q) begin
          status_d = mcmf_pkg::ST_INVALID;
        end else if (cnt == '0) begin
          status_d = blk_q ? mcmf_pkg::ST_TIMEOUT : mcmf_pkg::ST_EMPTY;
        end else begin
          head_d = next_slot(head);
          cnt_d  = cnt - 1'b1;
          ptr_we = cmd_i.exec;
          msg_re = cmd_i.exec;
        end
      end
      mcmf_pkg::KIND_CLEAR: begin
        if (!in_range_q) begin
          status_d = mcmf_pkg::ST_INVALID;
        end else begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = '0;
          ptr_we = cmd_i.exec;
        end
      end
      mcmf_pkg::KIND_QUERY: begin
        if (!in_range_q) status_d = mcmf_pkg::ST_INVALID;
      end
      default: begin
        status_d = mcmf_pkg::ST_INVALID;
      end
    endcase
  end

  // message memory
  logic [MSG_WIDTH-1:0]         msg_mem [MsgEntries];
  logic [MSG_WIDTH-1:0]         msg_rd_q;
  logic [ChIdxW+SlotW-1:0]      msg_addr;

  assign msg_addr = {ch_q, (msg_we ? tail : head)};

  always_ff @(posedge clk_i) begin
    if (msg_we) begin
      msg_mem[msg_addr] <= msg_q;
    end
    if (msg_re) begin
      msg_rd_q <= msg_mem[msg_addr];
    end
  end

  // result registers
  logic deq_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deq_ok_q <= 1'b0;
    end else if (cmd_i.exec) begin
      deq_ok_q <= msg_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o   <= status_d;
      pending_o  <= in_range_q ? mcmf_pkg::PendW'(cnt_d) : '0;
      is_full_o  <= in_range_q ? (cnt_d == CntW'(DEPTH)) : 1'b1;
      is_empty_o <= in_range_q ? (cnt_d == '0) : 1'b1;
    end
  end

  assign message_out_o = deq_ok_q ? mcmf_pkg::MsgPortW'(msg_rd_q) : '0;

endmodule

`default_nettype wire

// ----- rtl/multi_channel_message_fifo.sv -----
// Top level of the multi-channel message FIFO.
// Instantiates mcmf_ctrl and mcmf_datapath; uses mcmf_pkg and the assertion macros.
//
// Usage:
//   Request channel: drive kind_i, channel_i, message_in_i and blocking_i with
//   start_i high; the request transfers at a rising edge where busy_o is low.
//   Result channel: done_o is high for exactly one cycle, in the respond state
//   that follows the execute state entered at the request transfer, with
//   status_o, message_out_o, pending_o, is_full_o and is_empty_o valid in that
//   cycle. The receiver cannot stall; results are never held.
//   Each request first reads the channel's head/tail/count from the pointer
//   memory at the transfer, then updates it and accesses the message memory
//   in the execute state; a new request may transfer in the cycle the result
//   is shown.
//   Configuration: cfg_valid_i with cfg_data_i writes channel_open_mask; the
//   channel is always ready. Write only while no request is in flight.
//   Reset: rst_ni clears the open mask, the controller and the per-channel
//   pointer valid bits, so every queue reads as empty at once; no clearing
//   pass. Message slots are undefined until written.
`default_nettype none
`include "multi_channel_message_fifo_macros.svh"

module multi_channel_message_fifo #(
  parameter int CHANNELS  = 16,
  parameter int DEPTH     = 16,
  parameter int MSG_WIDTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [mcmf_pkg::KindW-1:0]       kind_i,
  input  wire logic [mcmf_pkg::ChanW-1:0]       channel_i,
  input  wire logic [mcmf_pkg::MsgPortW-1:0]    message_in_i,
  input  wire logic                             blocking_i,
  output logic                                  done_o,
  output logic [mcmf_pkg::StatusW-1:0]          status_o,
  output logic [mcmf_pkg::MsgPortW-1:0]         message_out_o,
  output logic [mcmf_pkg::PendW-1:0]            pending_o,
  output logic                                  is_full_o,
  output logic                                  is_empty_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [mcmf_pkg::MaskW-1:0]       cfg_data_i
);

  mcmf_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  assign done_o      = cmd.respond;

  mcmf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  mcmf_datapath #(
    .CHANNELS  (CHANNELS),
    .DEPTH     (DEPTH),
    .MSG_WIDTH (MSG_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .channel_i     (channel_i),
    .message_in_i  (message_in_i),
    .blocking_i    (blocking_i),
    .status_o      (status_o),
    .message_out_o (message_out_o),
    .pending_o     (pending_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o)
  );

  `MCMF_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && !done_o, "busy must follow transfer")
  `MCMF_ASSERT_NEXT(a_busy_done, busy_o, done_o && !busy_o, "result must follow busy cycle")
  `MCMF_ASSERT_NOW(a_msg_ok, done_o && (message_out_o != '0), status_o == mcmf_pkg::ST_OK, "word without dequeue")
  `MCMF_ASSERT_NOW(a_pend_flags, done_o && (pending_o != '0), !is_empty_o, "nonzero count reported empty")

endmodule

`default_nettype wire
